### src/fsp_pkg.sv
// ----------------------------------------------------------------------------
// fsp_pkg
// Types, character codes and helpers shared by the format spec parser.
// ----------------------------------------------------------------------------
package fsp_pkg;

    // accumulator widths before clamping to the output field widths
    localparam int NUM_BITS   = 16;
    localparam int COUNT_BITS = 8;

    localparam int NUM_W = (NUM_BITS < 16) ? NUM_BITS : 16;
    localparam int CNT_W = (COUNT_BITS < 8) ? COUNT_BITS : 8;

    localparam logic [NUM_W-1:0] NUM_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam int NUM_FLAGS = 5;

    // flag slots
    localparam int FLAG_LEFT  = 0;
    localparam int FLAG_ZERO  = 1;
    localparam int FLAG_SIGN  = 2;
    localparam int FLAG_SPACE = 3;
    localparam int FLAG_ALT   = 4;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_DOT     = 8'h2e;

    localparam logic [7:0]  TYPE_NONE    = 8'h00;
    localparam logic [16:0] PREC_ABSENT  = 17'h1ffff;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FLAGS,
        PH_WIDTH,
        PH_PREC
    } phase_t;

    typedef struct packed {
        phase_t                             phase;
        logic [NUM_FLAGS-1:0][CNT_W-1:0]    flag_cnt;
        logic [NUM_W-1:0]                   width_acc;
        logic                               prec_seen;
        logic [NUM_W-1:0]                   prec_acc;
        logic [CNT_W-1:0]                   length_acc;
    } spec_state_t;

    typedef struct packed {
        logic [7:0]         conv_type;
        logic [7:0]         left_count;
        logic [7:0]         zero_count;
        logic [7:0]         sign_count;
        logic [7:0]         space_count;
        logic [7:0]         alt_count;
        logic [15:0]        field_width;
        logic signed [16:0] precision;
        logic [7:0]         spec_length;
        logic               ended_early;
    } spec_result_t;

    localparam spec_state_t SPEC_CLEAR = '{
        phase:      PH_IDLE,
        flag_cnt:   '0,
        width_acc:  '0,
        prec_seen:  1'b0,
        prec_acc:   '0,
        length_acc: '0
    };

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v != CNT_MAX) ? v + 1'b1 : v;
    endfunction

    // acc * 10 + d as shifts and adds, clamped to the maximum
    function automatic logic [NUM_W-1:0] add_digit(input logic [NUM_W-1:0] acc,
                                                  input logic [3:0] d);
        logic [NUM_W+3:0] ext;
        logic [NUM_W+3:0] n;
        ext = (NUM_W+4)'(acc);
        n   = (ext << 3) + (ext << 1) + (NUM_W+4)'(d);
        add_digit = (n > (NUM_W+4)'(NUM_MAX)) ? NUM_MAX : n[NUM_W-1:0];
    endfunction

endpackage

### src/fsp_step.sv
// ----------------------------------------------------------------------------
// fsp_step
// Next-state and result logic for one byte of the format string.
// ----------------------------------------------------------------------------
module fsp_step
    import fsp_pkg::*;
(
    input  spec_state_t  state,
    input  logic [7:0]   char_in,
    input  logic         is_final,
    output spec_state_t  state_next,
    output logic         emit,
    output spec_result_t result
);

    spec_state_t work;
    logic        is_digit;
    logic        is_flag;
    int unsigned flag_idx;
    logic [7:0]  res_type;
    logic        res_early;

    always_comb
    begin
        is_digit = char_in inside {[CH_ZERO:CH_NINE]};
        is_flag  = 1'b1;
        flag_idx = FLAG_LEFT;
        case (char_in)
            CH_MINUS: flag_idx = FLAG_LEFT;
            CH_ZERO:  flag_idx = FLAG_ZERO;
            CH_PLUS:  flag_idx = FLAG_SIGN;
            CH_SPACE: flag_idx = FLAG_SPACE;
            CH_HASH:  flag_idx = FLAG_ALT;
            default:  is_flag = 1'b0;
        endcase
    end

    always_comb
    begin
        work       = state;
        emit       = 1'b0;
        res_type   = TYPE_NONE;
        res_early  = 1'b0;
        state_next = state;

        if (state.phase == PH_IDLE) begin
            if (char_in == CH_PERCENT) begin
                work            = SPEC_CLEAR;
                work.length_acc = CNT_W'(1);
                work.phase      = PH_FLAGS;
            end
        end else begin
            work.length_acc = sat_inc(state.length_acc);
            if (state.phase == PH_FLAGS && is_flag) begin
                work.flag_cnt[flag_idx[2:0]] = sat_inc(state.flag_cnt[flag_idx[2:0]]);
            end else if (state.phase != PH_PREC && is_digit) begin
                work.width_acc = add_digit(state.width_acc, char_in[3:0]);
                work.phase     = PH_WIDTH;
            end else if (state.phase != PH_PREC && char_in == CH_DOT) begin
                work.prec_seen = 1'b1;
                work.prec_acc  = '0;
                work.phase     = PH_PREC;
            end else if (state.phase == PH_PREC && is_digit) begin
                work.prec_acc = add_digit(state.prec_acc, char_in[3:0]);
            end else begin
                // any other byte closes the spec as its type
                emit     = 1'b1;
                res_type = char_in;
            end
        end

        // string ends with the spec still open
        if (!emit && is_final && work.phase != PH_IDLE) begin
            emit      = 1'b1;
            res_early = 1'b1;
        end

        if (emit || is_final)
            state_next = SPEC_CLEAR;
        else
            state_next = work;
    end

    always_comb
    begin
        result.conv_type   = res_type;
        result.left_count  = 8'(work.flag_cnt[FLAG_LEFT]);
        result.zero_count  = 8'(work.flag_cnt[FLAG_ZERO]);
        result.sign_count  = 8'(work.flag_cnt[FLAG_SIGN]);
        result.space_count = 8'(work.flag_cnt[FLAG_SPACE]);
        result.alt_count   = 8'(work.flag_cnt[FLAG_ALT]);
        result.field_width = 16'(work.width_acc);
        result.precision   = work.prec_seen ? 17'(work.prec_acc) : PREC_ABSENT;
        result.spec_length = 8'(work.length_acc);
        result.ended_early = res_early;
    end

endmodule

### src/format_spec_parser.sv
// ----------------------------------------------------------------------------
// format_spec_parser
// Parses printf-style format specs from a byte stream.
// ----------------------------------------------------------------------------
// Input channel s_*: one byte of the format string per item, s_tlast marks
// the last byte of the string. Output channel m_*: one item per spec, sent
// when its type byte arrives or when the string ends inside an open spec
// (then the type is zero and m_tuser is set).
// A byte is first held in the input register; when it advances, the parser
// state and the result register update together, so a result is shown in
// the cycle after its byte advances. One byte per cycle is sustained while
// the output is not stalled, as the parser state register takes every byte;
// it holds the flag counts, width, precision and length of the open spec.
// Reset empties both registers and leaves the parser outside any spec.
// When m_tready is low a waiting result holds, one more byte can still be taken
// into the input register and s_tready then drops until the result leaves.
// ----------------------------------------------------------------------------
module format_spec_parser
    import fsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_in [7:0]
    input  logic        s_tlast,   // is_final

    output logic        m_tvalid,
    input  logic        m_tready,
    // conv_type [7:0], left_count [15:8], zero_count [23:16], sign_count [31:24],
    // space_count [39:32], alt_count [47:40], field_width [63:48],
    // precision [80:64], spec_length [88:81], zero fill [95:89]
    output logic [95:0] m_tdata,
    output logic        m_tuser    // ended_early
);

    logic         in_valid_reg;
    logic [7:0]   char_reg;
    logic         final_reg;

    spec_state_t  state_reg;
    spec_state_t  state_next;

    logic         out_valid_reg;
    spec_result_t result_reg;
    spec_result_t result_next;
    logic         emit;

    logic         advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    fsp_step u_step (
        .state      (state_reg),
        .char_in    (char_reg),
        .is_final   (final_reg),
        .state_next (state_next),
        .emit       (emit),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            char_reg  <= s_tdata;
            final_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= SPEC_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= emit;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.ended_early;
    assign m_tdata  = {7'b0,
                       result_reg.spec_length,
                       result_reg.precision,
                       result_reg.field_width,
                       result_reg.alt_count,
                       result_reg.space_count,
                       result_reg.sign_count,
                       result_reg.zero_count,
                       result_reg.left_count,
                       result_reg.conv_type};

endmodule
